[hdl/tdp_pkg.sv]
// Shared constants for the trial-division primality block.
// No dependencies; used by trial_division_primality.
package tdp_pkg;

  // Width of the candidate field on the input port
  localparam int unsigned CANDIDATE_WIDTH = 32;

  // Below this value a number is never prime
  localparam int unsigned LOWEST_PRIME = 2;

  // Below this value (and at or above LOWEST_PRIME) a number is always prime
  localparam int unsigned FIRST_NONTRIVIAL = 4;

  // First odd trial divisor; even divisors are settled by the low bit
  localparam int unsigned FIRST_DIVISOR = 3;

endpackage

[hdl/trial_division_primality.sv]
// Trial-division primality test with bit-serial restoring dividers.
// Depends on tdp_pkg for field width and the small-number constants.
//
//   channel | ports                                  | direction
//   --------+----------------------------------------+----------
//   input   | in_valid, in_stall, in_candidate[31:0] | in
//   result  | out_valid, out_stall, out_is_prime     | out
//
// Candidates below 4 and even ones are settled without a division. Odd ones
// run rounds: each of the REMAINDER_UNITS dividers shifts one quotient bit
// per cycle, then a check state tests the results. A round tests
// REMAINDER_UNITS odd divisors; an odd prime runs rounds until the divisors
// pass its square root, and an odd composite stops at the round that finds
// its smallest factor.
// One candidate is in work at a time; a new one is taken while the last
// result waits on out_stall. Reset clears the control state.
module trial_division_primality #(
  parameter int unsigned NUMBER_WIDTH    = 32,
  parameter int unsigned REMAINDER_UNITS = 1
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [tdp_pkg::CANDIDATE_WIDTH-1:0]  in_candidate,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 out_is_prime
);

  localparam int unsigned W  = NUMBER_WIDTH;
  localparam int unsigned U  = REMAINDER_UNITS;
  localparam int unsigned CW = $clog2(W);
  localparam int unsigned CAND_W = tdp_pkg::CANDIDATE_WIDTH;

  typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_CHECK, ST_HOLD} state_t;

  state_t          state_r;
  logic            out_valid_r;
  logic            out_is_prime_r;
  logic            hold_flag_r;

  logic [W-1:0]    n_r;
  logic [CW-1:0]   bit_cnt_r;
  logic [W-1:0]    rem_r  [U];
  logic [W-1:0]    quot_r [U];
  logic [W-1:0]    dv_r   [U];

  logic [W-1:0]    rem_nxt  [U];
  logic [W-1:0]    quot_nxt [U];
  logic [U-1:0]    in_range;
  logic [U-1:0]    rem_zero;

  logic [W-1:0]    n_in;
  logic            accept;
  logic            out_free;
  logic            load_out;
  logic            trivial;
  logic            trivial_flag;
  logic            composite;
  logic            check_done;
  logic            check_flag;
  logic            start_div;
  logic            next_round;

  // Keep the low NUMBER_WIDTH bits of the candidate, zero-extending when NUMBER_WIDTH is wider
  generate
    if (W > CAND_W) begin : g_wide
      assign n_in = {{(W - CAND_W){1'b0}}, in_candidate};
    end else if (W == CAND_W) begin : g_same
      assign n_in = in_candidate;
    end else begin : g_narrow
      assign n_in = in_candidate[W-1:0];
    end
  endgenerate

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  // Settle small and even candidates without a division
  always_comb begin
    trivial      = 1'b1;
    trivial_flag = 1'b0;
    priority if (n_in < W'(tdp_pkg::LOWEST_PRIME)) begin
      trivial_flag = 1'b0;
    end else if (n_in < W'(tdp_pkg::FIRST_NONTRIVIAL)) begin
      trivial_flag = 1'b1;
    end else if (!n_in[0]) begin
      trivial_flag = 1'b0;
    end else begin
      trivial = 1'b0;
    end
  end

  // One restoring-division step per unit: shift in the next dividend bit
  always_comb begin
    logic [W:0] trial;
    logic [W:0] diff;
    logic       ge;
    for (int u = 0; u < U; u++) begin
      trial       = {rem_r[u], quot_r[u][W-1]};
      diff        = trial - {1'b0, dv_r[u]};
      ge          = (trial >= {1'b0, dv_r[u]});
      rem_nxt[u]  = ge ? diff[W-1:0] : trial[W-1:0];
      quot_nxt[u] = {quot_r[u][W-2:0], ge};
      in_range[u] = (dv_r[u] <= quot_r[u]);
      rem_zero[u] = (rem_r[u] == '0);
    end
  end

  // Divisors above n/d end the search; any in-range zero remainder is a factor
  assign composite  = |(in_range & rem_zero);
  assign check_done = composite || !(&in_range);
  assign check_flag = !composite;

  assign start_div  = accept && !trivial;
  assign next_round = (state_r == ST_CHECK) && !check_done;

  // Load the result register whenever a verdict is ready and the register is free
  assign load_out = out_free && ((state_r == ST_IDLE && accept && trivial) ||
                                 (state_r == ST_CHECK && check_done) ||
                                 (state_r == ST_HOLD));

  // Control state and the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // load a new result, else drop the old one once it transfers
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            if (!trivial) begin
              state_r <= ST_DIV;
            end else if (out_free) begin
              out_is_prime_r <= trivial_flag;
            end else begin
              hold_flag_r <= trivial_flag;
              state_r     <= ST_HOLD;
            end
          end
        end
        ST_DIV: begin
          if (bit_cnt_r == '0) begin
            state_r <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (!check_done) begin
            state_r <= ST_DIV;
          end else if (out_free) begin
            out_is_prime_r <= check_flag;
            state_r        <= ST_IDLE;
          end else begin
            hold_flag_r <= check_flag;
            state_r     <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (out_free) begin
            out_is_prime_r <= hold_flag_r;
            state_r        <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // Divider shift registers, bit counter and trial divisors
  always_ff @(posedge clk) begin
    if (start_div) begin
      n_r       <= n_in;
      bit_cnt_r <= CW'(W - 1);
      for (int u = 0; u < U; u++) begin
        quot_r[u] <= n_in;
        rem_r[u]  <= '0;
        dv_r[u]   <= W'(tdp_pkg::FIRST_DIVISOR + 2 * u);
      end
    end else if (next_round) begin
      bit_cnt_r <= CW'(W - 1);
      for (int u = 0; u < U; u++) begin
        quot_r[u] <= n_r;
        rem_r[u]  <= '0;
        dv_r[u]   <= dv_r[u] + W'(2 * U);
      end
    end else if (state_r == ST_DIV) begin
      bit_cnt_r <= bit_cnt_r - 1'b1;
      for (int u = 0; u < U; u++) begin
        quot_r[u] <= quot_nxt[u];
        rem_r[u]  <= rem_nxt[u];
      end
    end
  end

  assign out_valid    = out_valid_r;
  assign out_is_prime = out_is_prime_r;

  // Bit counter steps down by one through a division round
  a_bit_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && bit_cnt_r != '0) |=>
      (state_r == ST_DIV && bit_cnt_r == $past(bit_cnt_r) - 1'b1))
    else $error("bit counter did not step during division");

  // A division round ends only in the check cycle
  a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |=> (state_r == ST_DIV || state_r == ST_CHECK))
    else $error("division round left without a check");

  // The first unit's trial divisor stays odd
  a_odd_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CHECK) |-> dv_r[0][0])
    else $error("even trial divisor");

  // The hold state is entered only behind a waiting result
  a_hold_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_HOLD) |-> out_valid_r)
    else $error("result held while output register empty");

endmodule
